### hdl/txsba_pkg.sv
// txsba_pkg: shared constants, codes and control types of the transmit slot
// bandwidth admission block. No dependencies; imported by every other file.
package txsba_pkg;

    // Slot table and rate format
    localparam int NUM_SLOTS      = 10;
    localparam int RATE_FRAC_BITS = 16;

    // Fixed field widths
    localparam int MODE_W   = 1;
    localparam int PERIOD_W = 16;
    localparam int BYTES_W  = 16;
    localparam int HANDLE_W = 4;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int LIMIT_W  = 20;

    // Derived widths
    localparam int SLOT_IW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int RATE_W   = BYTES_W + RATE_FRAC_BITS;
    localparam int TOTAL_W  = RATE_W + $clog2(NUM_SLOTS + 1);
    localparam int LIMFX_W  = LIMIT_W + RATE_FRAC_BITS;
    localparam int CMP_W    = ((TOTAL_W > LIMFX_W) ? TOTAL_W : LIMFX_W) + 1;
    localparam int CNT_W    = $clog2(RATE_W + 1);

    // Configuration port
    localparam int APB_AW   = 2;
    localparam int APB_DW   = 32;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(180000);

    // Request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED     = 3'd0,
        ST_ZERO_PERIOD = 3'd1,
        ST_NO_SLOT     = 3'd2,
        ST_OVER_LIMIT  = 3'd3,
        ST_FREED       = 3'd4,
        ST_BAD_HANDLE  = 3'd5
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // latch request, preload divider
        logic div_step;  // one quotient bit
        logic commit;    // write result and update slot table
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic skip_div;  // free request or early refusal
        logic div_done;  // all quotient bits produced
        logic out_free;  // output register can take a result
    } t_stat;

endpackage

### hdl/txsba_if.sv
// txsba_if: valid/ready channel interfaces for requests and results.
// Depends on txsba_pkg for field widths.
interface txsba_req_if import txsba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [PERIOD_W-1:0] period;
    logic [BYTES_W-1:0]  byte_count;
    logic [HANDLE_W-1:0] handle;

    modport source (output valid, mode, period, byte_count, handle, input ready);
    modport sink   (input valid, mode, period, byte_count, handle, output ready);
endinterface

interface txsba_rsp_if import txsba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, status, slot, input ready);
    modport sink   (input valid, status, slot, output ready);
endinterface

### hdl/txsba_ctrl.sv
// txsba_ctrl: request sequencer (accept, decode, divide, commit).
// Depends on txsba_pkg; drives t_cmd into txsba_dp and reads t_stat back.
module txsba_ctrl import txsba_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_req_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = i_stat.skip_div ? S_DONE : S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/txsba_dp.sv
// txsba_dp: request registers, restoring divider, slot table, running total
// and result register. Depends on txsba_pkg; sequenced by txsba_ctrl.
module txsba_dp import txsba_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [LIMIT_W-1:0]  i_rate_limit,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [PERIOD_W-1:0] i_period,
    input  logic [BYTES_W-1:0]  i_byte_count,
    input  logic [HANDLE_W-1:0] i_handle,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot
);

    // Latched request
    logic [MODE_W-1:0]   r_mode;
    logic [PERIOD_W-1:0] r_period;
    logic [HANDLE_W-1:0] r_handle;
    logic [SLOT_IW-1:0]  r_found;
    logic                r_have_free;

    // Divider
    logic [PERIOD_W-1:0] r_rem;
    logic [RATE_W-1:0]   r_quo;
    logic [CNT_W-1:0]    r_cnt;
    logic [PERIOD_W:0]   rem_sh;
    logic                q_bit;

    // Slot table and total
    logic                r_busy [NUM_SLOTS];
    logic [RATE_W-1:0]   r_rate [NUM_SLOTS];
    logic [TOTAL_W-1:0]  r_total;

    // Result register
    logic                r_out_valid;
    t_status             r_status;
    logic [SLOT_W-1:0]   r_slot;

    logic [SLOT_IW-1:0]  found;
    logic                have_free;
    logic                bad_handle;
    logic                zero_period;
    logic                is_free;
    logic [SLOT_IW-1:0]  hidx;
    logic [CMP_W-1:0]    sum;
    logic [CMP_W-1:0]    limit_fx;
    logic                over_limit;
    logic                out_free;

    // Lowest free slot
    always_comb begin
        found     = '0;
        have_free = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                found     = SLOT_IW'(i);
                have_free = 1'b1;
            end
        end
    end

    // Request decode
    assign is_free     = (r_mode == MODE_FREE);
    assign hidx        = r_handle[SLOT_IW-1:0];
    assign bad_handle  = ({1'b0, r_handle} >= (HANDLE_W + 1)'(NUM_SLOTS));
    assign zero_period = (r_period == '0);

    // Admission check
    assign sum        = CMP_W'(r_total) + CMP_W'(r_quo);
    assign limit_fx   = CMP_W'({i_rate_limit, {RATE_FRAC_BITS{1'b0}}});
    assign over_limit = (sum > limit_fx);

    assign out_free = !r_out_valid || i_out_ready;

    assign o_stat.skip_div = is_free || zero_period || !r_have_free;
    assign o_stat.div_done = (r_cnt == '0);
    assign o_stat.out_free = out_free;

    // Request registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode      <= i_mode;
            r_period    <= i_period;
            r_handle    <= i_handle;
            r_found     <= found;
            r_have_free <= have_free;
        end
    end

    // Restoring divider: one quotient bit per step
    assign rem_sh = {r_rem, r_quo[RATE_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_period});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= CNT_W'(RATE_W);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= '0;
            r_quo <= {i_byte_count, {RATE_FRAC_BITS{1'b0}}};
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? PERIOD_W'(rem_sh - {1'b0, r_period}) : rem_sh[PERIOD_W-1:0];
            r_quo <= {r_quo[RATE_W-2:0], q_bit};
        end
    end

    // Slot busy flags and total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_busy[i] <= 1'b0;
            end
            r_total <= '0;
        end else if (i_cmd.commit) begin
            if (is_free) begin
                if (!bad_handle && r_busy[hidx]) begin
                    r_busy[hidx] <= 1'b0;
                    r_total      <= r_total - TOTAL_W'(r_rate[hidx]);
                end
            end else if (!zero_period && r_have_free && !over_limit) begin
                r_busy[r_found] <= 1'b1;
                r_total         <= TOTAL_W'(sum);
            end
        end
    end

    // Slot rates; only read while the slot is busy
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !is_free && !zero_period && r_have_free && !over_limit) begin
            r_rate[r_found] <= r_quo;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_slot <= '0;
            if (is_free) begin
                if (bad_handle) begin
                    r_status <= ST_BAD_HANDLE;
                end else begin
                    r_status <= ST_FREED;
                    r_slot   <= SLOT_W'(r_handle);
                end
            end else if (zero_period) begin
                r_status <= ST_ZERO_PERIOD;
            end else if (!r_have_free) begin
                r_status <= ST_NO_SLOT;
            end else if (over_limit) begin
                r_status <= ST_OVER_LIMIT;
            end else begin
                r_status <= ST_GRANTED;
                r_slot   <= SLOT_W'(r_found);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_slot      = r_slot;

    // A result never overwrites one that is still waiting
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> out_free)
        else $error("commit while result register blocked");

    // Divider never steps past its last quotient bit
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_cnt != '0))
        else $error("divider stepped with zero count");

    // Slot number is zero unless granted or freed
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !(r_status == ST_GRANTED || r_status == ST_FREED))
        |-> (r_slot == '0))
        else $error("nonzero slot on refusal");

    // A granted slot is marked busy after commit
    a_grant_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !is_free && !zero_period && r_have_free && !over_limit)
        |=> r_busy[$past(r_found)])
        else $error("granted slot not marked busy");

endmodule

### hdl/tx_slot_bandwidth_admission_top.sv
// Transmit slot bandwidth admission: top level with configuration register.
// Depends on txsba_pkg, txsba_if, txsba_ctrl and txsba_dp.
//
// Usage: requests arrive on i_req (valid/ready). mode 0 allocates a slot for
// byte_count bytes every period ticks; mode 1 releases slot handle. Each
// request yields exactly one result transfer on o_rsp carrying status and
// slot. rate_limit sits at every APB address; writes complete in the access
// cycle (pready is tied high) and reads return the current limit.
// Timing: one request at a time. A free request, or an allocate refused for
// zero period or no free slot, goes from decode straight to commit. An
// allocate that reaches the admission check first passes through the
// restoring divider, which produces one of the 32 quotient bits per cycle.
// A new request is taken once the previous result is in the output register,
// even if the receiver has not yet taken it. If the receiver stalls, that
// result holds and the following request waits at commit until it drains.
// Reset: all slots free, total rate zero, rate_limit 180000, no result
// pending.
module tx_slot_bandwidth_admission_top import txsba_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    txsba_req_if.sink         i_req,
    txsba_rsp_if.source       o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [LIMIT_W-1:0] r_rate_limit;
    t_cmd               cmd;
    t_stat              stat;

    // Configuration register: the whole address range maps to rate_limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && (paddr[APB_AW-1:2 - 2] == paddr)) begin
            r_rate_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = APB_DW'(r_rate_limit);

    // Sequencer
    txsba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath
    txsba_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_rate_limit (r_rate_limit),
        .i_mode       (i_req.mode),
        .i_period     (i_req.period),
        .i_byte_count (i_req.byte_count),
        .i_handle     (i_req.handle),
        .o_out_valid  (o_rsp.valid),
        .i_out_ready  (o_rsp.ready),
        .o_status     (o_rsp.status),
        .o_slot       (o_rsp.slot)
    );

endmodule
